// File: hdl/edd_pkg.sv
`default_nettype none

package edd_pkg;

   // Longest string that the block holds; longer strings are cut and flagged.
   localparam int MAX_LEN = 64;

   localparam int SYM_W  = 8;
   localparam int MODE_W = 2;
   localparam int DIST_W = 7;

   // Lengths and row entries run from 0 to MAX_LEN.
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ROW_W  = LEN_W;
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   localparam int DIST_MAX = (2 ** DIST_W) - 1;

   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SYM_W-1:0]  symbol;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              length_overflow;
      logic              order_error;
   } rsp_type;

   // Write and read commands from the sequencer to the two memories.
   typedef struct packed {
      logic              store_we;
      logic [ADDR_W-1:0] store_waddr;
      logic [SYM_W-1:0]  store_wdata;
      logic              row_we;
      logic [ADDR_W-1:0] row_waddr;
      logic [ROW_W-1:0]  row_wdata;
      logic [ADDR_W-1:0] rd_addr;
   } mem_cmd_type;

   // Clamp a row value to the width of the reported distance.
   function automatic logic [DIST_W-1:0] sat_dist(input logic [ROW_W-1:0] d);
      logic [ROW_W+DIST_W-1:0] wide;
      wide = {{DIST_W{1'b0}}, d};
      if (wide > (ROW_W + DIST_W)'(DIST_MAX)) begin
         return DIST_W'(DIST_MAX);
      end
      return wide[DIST_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/edd_ram.sv
`default_nettype none

module edd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/edd_cell.sv
`default_nettype none

// One cell of the distance recurrence: min(left + 1, up + 1, diag + cost).
module edd_cell (
   input  wire logic [edd_pkg::ROW_W-1:0] left,
   input  wire logic [edd_pkg::ROW_W-1:0] up,
   input  wire logic [edd_pkg::ROW_W-1:0] diag,
   input  wire logic [edd_pkg::SYM_W-1:0] sym_a,
   input  wire logic [edd_pkg::SYM_W-1:0] sym_b,
   output logic      [edd_pkg::ROW_W-1:0] cell_out
);

   logic [edd_pkg::ROW_W-1:0] edge_min;
   logic [edd_pkg::ROW_W:0]   edge_cost;
   logic [edd_pkg::ROW_W:0]   diag_cost;

   always_comb begin
      edge_min  = (left < up) ? left : up;
      edge_cost = {1'b0, edge_min} + (edd_pkg::ROW_W + 1)'(1);
      diag_cost = {1'b0, diag} + (edd_pkg::ROW_W + 1)'(sym_a != sym_b);
      cell_out  = (diag_cost < edge_cost) ? diag_cost[edd_pkg::ROW_W-1:0]
                                          : edge_cost[edd_pkg::ROW_W-1:0];
   end

endmodule

`default_nettype wire

// File: hdl/edd_seq.sv
`default_nettype none

module edd_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire edd_pkg::req_type          req_data,
   output logic                           req_ready,
   input  wire logic [edd_pkg::SYM_W-1:0] store_rd,
   input  wire logic [edd_pkg::ROW_W-1:0] row_rd,
   input  wire logic                      rsp_free,
   output edd_pkg::mem_cmd_type           cmd,
   output logic                           rsp_load,
   output edd_pkg::rsp_type               rsp_next
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [edd_pkg::LEN_W-1:0] first_len_ff, first_len_in;
   logic [edd_pkg::LEN_W-1:0] second_cnt_ff, second_cnt_in;
   logic                      second_started_ff, second_started_in;
   logic                      overflow_ff, overflow_in;
   logic                      order_ff, order_in;
   logic [edd_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic [edd_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic [edd_pkg::ROW_W-1:0] left_ff, left_in;
   logic [edd_pkg::ROW_W-1:0] diag_ff, diag_in;

   logic [edd_pkg::LEN_W-1:0] len_m1;
   logic [edd_pkg::LEN_W-1:0] idx_next;
   logic [edd_pkg::ROW_W-1:0] cell_out;
   logic [edd_pkg::ROW_W-1:0] final_row;

   edd_cell u_cell (
      .left     (left_ff),
      .up       (row_rd),
      .diag     (diag_ff),
      .sym_a    (store_rd),
      .sym_b    (sym_ff),
      .cell_out (cell_out)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign len_m1    = first_len_ff - edd_pkg::LEN_W'(1);
   assign idx_next  = idx_ff + edd_pkg::LEN_W'(1);

   // With an empty first string the last row entry is entry zero, the second count.
   assign final_row = (first_len_ff == '0) ? second_cnt_ff : row_rd;

   always_comb begin
      rsp_next.distance        = edd_pkg::sat_dist(final_row);
      rsp_next.length_overflow = overflow_ff;
      rsp_next.order_error     = order_ff;
   end

   always_comb begin
      state_in          = state_ff;
      first_len_in      = first_len_ff;
      second_cnt_in     = second_cnt_ff;
      second_started_in = second_started_ff;
      overflow_in       = overflow_ff;
      order_in          = order_ff;
      idx_in            = idx_ff;
      sym_in            = sym_ff;
      left_in           = left_ff;
      diag_in           = diag_ff;
      cmd               = '0;
      cmd.rd_addr       = len_m1[edd_pkg::ADDR_W-1:0];
      rsp_load          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.mode)
                  edd_pkg::MODE_FIRST: begin
                     if (second_started_ff) begin
                        order_in = 1'b1;
                     end else if (first_len_ff >= edd_pkg::LEN_W'(edd_pkg::MAX_LEN)) begin
                        overflow_in = 1'b1;
                     end else begin
                        // Row entry n sits at address n - 1 and is initialized to n.
                        cmd.store_we    = 1'b1;
                        cmd.store_waddr = first_len_ff[edd_pkg::ADDR_W-1:0];
                        cmd.store_wdata = req_data.symbol;
                        cmd.row_we      = 1'b1;
                        cmd.row_waddr   = first_len_ff[edd_pkg::ADDR_W-1:0];
                        cmd.row_wdata   = first_len_ff + edd_pkg::ROW_W'(1);
                        first_len_in    = first_len_ff + edd_pkg::LEN_W'(1);
                     end
                  end
                  edd_pkg::MODE_SECOND: begin
                     cmd.rd_addr = '0;
                     if (second_cnt_ff >= edd_pkg::LEN_W'(edd_pkg::MAX_LEN)) begin
                        overflow_in = 1'b1;
                     end else begin
                        second_started_in = 1'b1;
                        second_cnt_in     = second_cnt_ff + edd_pkg::LEN_W'(1);
                        sym_in            = req_data.symbol;
                        left_in           = second_cnt_ff + edd_pkg::ROW_W'(1);
                        diag_in           = second_cnt_ff;
                        idx_in            = '0;
                        if (first_len_ff != '0) begin
                           state_in = S_WALK;
                        end
                     end
                  end
                  edd_pkg::MODE_FINISH: begin
                     state_in = S_FIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            cmd.row_we    = 1'b1;
            cmd.row_waddr = idx_ff[edd_pkg::ADDR_W-1:0];
            cmd.row_wdata = cell_out;
            cmd.rd_addr   = idx_next[edd_pkg::ADDR_W-1:0];
            left_in       = cell_out;
            diag_in       = row_rd;
            if (idx_next == first_len_ff) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_load          = 1'b1;
               first_len_in      = '0;
               second_cnt_in     = '0;
               second_started_in = 1'b0;
               overflow_in       = 1'b0;
               order_in          = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         first_len_ff      <= '0;
         second_cnt_ff     <= '0;
         second_started_ff <= 1'b0;
         overflow_ff       <= 1'b0;
         order_ff          <= 1'b0;
         idx_ff            <= '0;
      end else begin
         state_ff          <= state_in;
         first_len_ff      <= first_len_in;
         second_cnt_ff     <= second_cnt_in;
         second_started_ff <= second_started_in;
         overflow_ff       <= overflow_in;
         order_ff          <= order_in;
         idx_ff            <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
   end

endmodule

`default_nettype wire

// File: hdl/edit_distance_engine.sv
`default_nettype none

// Levenshtein edit distance engine. Send the first string as mode 0 beats, then
// the second string as mode 1 beats, then one mode 2 beat; that finish beat
// returns a single response beat with the distance and two flags, and clears the
// block for the next pair. Strings longer than MAX_LEN bytes are cut and set
// length_overflow; a first-string byte sent after second-string bytes is
// dropped and sets order_error. Mode 3 is accepted and ignored. Each
// second-string byte walks the dynamic-programming row, entries 1 to n, where n
// is the current first-string length (at most 64), through one read port of the
// row memory, one entry per cycle, and writes it back in place; no new beat is
// taken during the walk. A finish beat waits until the output register is free
// of the previous response, then loads its own response there. The request side keeps
// taking beats while a response waits. No clearing pass is needed after reset:
// row entry zero always equals the second-string count and is kept in a
// counter, and every other entry that is read has been written since the last
// finish.
module edit_distance_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire edd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output edd_pkg::rsp_type      rsp_data
);

   edd_pkg::mem_cmd_type      cmd;
   logic [edd_pkg::SYM_W-1:0] store_rd;
   logic [edd_pkg::ROW_W-1:0] row_rd;
   logic                      rsp_free;
   logic                      rsp_load;
   edd_pkg::rsp_type          rsp_next;

   logic                      rsp_valid_ff, rsp_valid_in;
   edd_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   // The first string's bytes, one per address.
   edd_ram #(
      .WIDTH (edd_pkg::SYM_W),
      .DEPTH (edd_pkg::MAX_LEN)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (cmd.store_we),
      .wr_addr (cmd.store_waddr),
      .wr_data (cmd.store_wdata),
      .rd_addr (cmd.rd_addr),
      .rd_data (store_rd)
   );

   // Row entries 1 to MAX_LEN, entry i at address i - 1. The walk writes entry
   // i while it reads entry i + 1, so the two ports never meet on one address.
   edd_ram #(
      .WIDTH (edd_pkg::ROW_W),
      .DEPTH (edd_pkg::MAX_LEN)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.row_we),
      .wr_addr (cmd.row_waddr),
      .wr_data (cmd.row_wdata),
      .rd_addr (cmd.rd_addr),
      .rd_data (row_rd)
   );

   edd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .store_rd  (store_rd),
      .row_rd    (row_rd),
      .rsp_free  (rsp_free),
      .cmd       (cmd),
      .rsp_load  (rsp_load),
      .rsp_next  (rsp_next)
   );

   // The output register is free when empty or when its beat leaves this cycle.
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new response is never loaded over one that has not been taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // A finish beat stops intake until its response is loaded.
   a_finish_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.mode == edd_pkg::MODE_FINISH) |=> !req_ready)
      else $error("request accepted while a finish is pending");

   // A response appears only after a load.
   a_rsp_from_load : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(rsp_load))
      else $error("response without a load");

   // No distance can exceed the longest string length.
   a_dist_range : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (int'(rsp_next.distance) <= edd_pkg::MAX_LEN))
      else $error("distance out of range");

endmodule

`default_nettype wire
